[rtl/assert_macros.svh]
// Assertion macros included by aes_block_encrypt.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/aes_pkg.sv]
// Shared types, constants and functions of the AES encryption block.
package aes_pkg;
  localparam int unsigned ROUND_KEY_SLOTS = 15;
  localparam int unsigned SLOT_W = $clog2(ROUND_KEY_SLOTS);
  localparam int unsigned ROUND_W = 4;
  localparam int unsigned NUM_COLS = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ENCRYPT = 1'b1;

  localparam logic [1:0] MODE_AES128 = 2'd0;
  localparam logic [1:0] MODE_AES192 = 2'd1;

  localparam logic [ROUND_W-1:0] ROUNDS_128 = 4'd10;
  localparam logic [ROUND_W-1:0] ROUNDS_192 = 4'd12;
  localparam logic [ROUND_W-1:0] ROUNDS_256 = 4'd14;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic round;
    logic last;
  } col_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tbl[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction
endpackage

[rtl/aes_block_encrypt.sv]
// AES encryption block: round key store, four column cells and a round sequencer.
// An encrypt beat steps through the KEY, ROUND and DONE states before its result is registered.
// Input, including key loads, is accepted only in IDLE, so a new block waits until the last result is registered.
// Each round uses one registered read of the round key RAM and one pass of the column cells.
// Reset (synchronous, active low) clears the sequencer, output valid and key size.
// The round key store is not cleared; an unwritten slot reads as undefined.
`include "assert_macros.svh"
module aes_block_encrypt (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: key_slot[3:0], word_high[67:4], word_low[131:68], zero fill [135:132]
  input  logic [135:0] s_axis_tdata,
  // tuser: opcode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: cipher_high[63:0], cipher_low[127:64]
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data
);
  aes_pkg::state_t state_r, state_nxt;
  logic [1:0]                   mode_r;
  logic [aes_pkg::ROUND_W-1:0]  round_r, round_nxt, nrounds;
  logic [127:0]                 blk_r;
  logic                         ovalid_r, ovalid_nxt;
  logic [127:0]                 odata_r;
  logic                         in_fire, we;
  logic [aes_pkg::SLOT_W-1:0]   raddr;
  logic [127:0]                 key_q, state_q, shifted;
  aes_pkg::col_ctrl_t           ctrl;
  logic [31:0]                  col_q [aes_pkg::NUM_COLS];

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign we = in_fire && (s_axis_tuser == aes_pkg::OP_LOAD) &&
              ({1'b0, s_axis_tdata[3:0]} < 5'(aes_pkg::ROUND_KEY_SLOTS));

  always_comb begin
    unique case (mode_r)
      aes_pkg::MODE_AES128: nrounds = aes_pkg::ROUNDS_128;
      aes_pkg::MODE_AES192: nrounds = aes_pkg::ROUNDS_192;
      default:              nrounds = aes_pkg::ROUNDS_256;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    unique case (state_r)
      aes_pkg::ST_IDLE: begin
        if (in_fire && s_axis_tuser == aes_pkg::OP_ENCRYPT) begin
          state_nxt = aes_pkg::ST_KEY;
          round_nxt = '0;
        end
      end
      aes_pkg::ST_KEY: begin
        state_nxt = aes_pkg::ST_ROUND;
        round_nxt = round_r + 1'b1;
      end
      aes_pkg::ST_ROUND: begin
        if (round_r == nrounds) begin
          state_nxt = aes_pkg::ST_DONE;
        end else begin
          round_nxt = round_r + 1'b1;
        end
      end
      aes_pkg::ST_DONE: begin
        if (!ovalid_r || m_axis_tready) begin
          state_nxt = aes_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_r == aes_pkg::ST_IDLE);
    raddr = (state_r == aes_pkg::ST_IDLE) ? '0 : aes_pkg::SLOT_W'(round_nxt);
    ctrl.load = (state_r == aes_pkg::ST_KEY);
    ctrl.round = (state_r == aes_pkg::ST_ROUND);
    ctrl.last = (round_r == nrounds);
    ovalid_nxt = ovalid_r;
    if (ovalid_r && m_axis_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (state_r == aes_pkg::ST_DONE && (!ovalid_r || m_axis_tready)) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aes_pkg::ST_IDLE;
      round_r <= '0;
      mode_r <= aes_pkg::MODE_AES128;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      blk_r <= {s_axis_tdata[67:4], s_axis_tdata[131:68]};
    end
    if (state_r == aes_pkg::ST_DONE && (!ovalid_r || m_axis_tready)) begin
      odata_r <= state_q;
    end
  end

  aes_ram #(.WIDTH(128), .DEPTH(aes_pkg::ROUND_KEY_SLOTS)) u_keys (
    .clk   (clk),
    .we    (we),
    .waddr (s_axis_tdata[aes_pkg::SLOT_W-1:0]),
    .wdata ({s_axis_tdata[67:4], s_axis_tdata[131:68]}),
    .raddr (raddr),
    .rdata (key_q)
  );

  // ShiftRows: row r of column c comes from column c + r.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      state_q[127-32*c -: 32] = col_q[c];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[127-32*c-8*r -: 8] = state_q[127-32*((c+r)%4)-8*r -: 8];
      end
    end
  end

  for (genvar c = 0; c < aes_pkg::NUM_COLS; c++) begin : g_col
    aes_col u_col (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_col   (blk_r[127-32*c -: 32]),
      .key_col    (key_q[127-32*c -: 32]),
      .shifted_in (shifted[127-32*c -: 32]),
      .col_q      (col_q[c])
    );
  end

  assign m_axis_tvalid = ovalid_r;
  assign m_axis_tdata = {odata_r[63:0], odata_r[127:64]};

  `ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_r != aes_pkg::ST_IDLE, !s_axis_tready, "ready while busy")
  `ASSERT_NEXT(a_hold_out, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
  `ASSERT_IMPL(a_round_range, clk, rst_n, state_r == aes_pkg::ST_ROUND, round_r != '0 && round_r <= nrounds, "round out of range")
endmodule

[rtl/aes_ram.sv]
// Generic single-port-write RAM with registered read.
module aes_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/aes_col.sv]
// 32-bit cell: AddRoundKey; rounds add SubBytes, MixColumns unless last.
module aes_col (
  input  logic                clk,
  input  aes_pkg::col_ctrl_t  ctrl,
  input  logic [31:0]         load_col,
  input  logic [31:0]         key_col,
  input  logic [31:0]         shifted_in,
  output logic [31:0]         col_q
);
  logic [31:0] col_r;
  logic [31:0] col_nxt;
  logic [7:0]  a0, a1, a2, a3, all;
  logic [31:0] mixed;

  always_comb begin
    a0 = aes_pkg::sbox(shifted_in[31:24]);
    a1 = aes_pkg::sbox(shifted_in[23:16]);
    a2 = aes_pkg::sbox(shifted_in[15:8]);
    a3 = aes_pkg::sbox(shifted_in[7:0]);
    all = a0 ^ a1 ^ a2 ^ a3;
    if (ctrl.last) begin
      mixed = {a0, a1, a2, a3};
    end else begin
      mixed = {a0 ^ all ^ aes_pkg::xtime(a0 ^ a1), a1 ^ all ^ aes_pkg::xtime(a1 ^ a2),
               a2 ^ all ^ aes_pkg::xtime(a2 ^ a3), a3 ^ all ^ aes_pkg::xtime(a3 ^ a0)};
    end
    if (ctrl.load) begin
      col_nxt = load_col ^ key_col;
    end else if (ctrl.round) begin
      col_nxt = mixed ^ key_col;
    end else begin
      col_nxt = col_r;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end

  assign col_q = col_r;
endmodule
